### rtl/blind_motor_position_controller_defines.svh
// Assertion helpers for the blind motor position controller.
// All checks sample on clk and are off while arst_n is low.
`ifndef BLIND_MOTOR_POSITION_CONTROLLER_DEFINES_SVH
`define BLIND_MOTOR_POSITION_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define BMPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BMPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bmpc_pkg.sv
package bmpc_pkg;

	localparam int ANGLE_W  = 9;
	localparam int RAW_W    = 12;
	localparam int LIMIT_W  = 10;
	localparam int HOME_W   = 16;
	localparam int PROD_W   = 21;
	localparam int IDX_W    = 3;

	localparam int SCALE_MUL = 359;

	// register indexes (byte address / 4)
	localparam logic [IDX_W-1:0] REG_SLACK      = 3'd0;
	localparam logic [IDX_W-1:0] REG_MIN_ANGLE  = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_ANGLE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_HOLD_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_HOME_LIMIT = 3'd4;

	localparam logic [ANGLE_W-1:0] SLACK_RST      = 9'd4;
	localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST  = 9'd200;
	localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST  = 9'd345;
	localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST = 10'd100;
	localparam logic [LIMIT_W-1:0] HOME_LIMIT_RST = 10'd50;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX_DEG  = 9'd359;

	typedef enum logic [1:0] {
		DRIVE_STOP = 2'd0,
		DRIVE_FWD  = 2'd1,
		DRIVE_BACK = 2'd2
	} drive_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_HOMING = 2'd1,
		MODE_MANUAL = 2'd2
	} mode_t;

	// floor(p / 4095) for p <= 4095*359: (p + (p >> 12) + 1) >> 12
	function automatic logic [ANGLE_W-1:0] div4095(input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] sum;
		sum = p + (p >> RAW_W) + PROD_W'(1);
		return sum[RAW_W +: ANGLE_W];
	endfunction

endpackage

### rtl/blind_motor_position_controller.sv
// Blind motor position controller.
// Input stream (s_axis): one transaction per tick carrying both button
// levels and a 12-bit encoder reading. Output stream (m_axis): exactly one
// result transaction per input with motor drive, target angle, mode and the
// measured angle in degrees (raw*359/4095, truncated).
// APB port: five registers at byte addresses 0,4,8,12,16 (slack, min angle,
// max angle, hold limit, home limit); pready is tied high, writes land on the
// access cycle. Only write config while the stream is drained.
// Pipeline: stage 1 then stage 2 from input transaction to result. Stage 1 holds the
// buttons and the 12x9 scale product; stage 2 does the divide by 4095, the
// button/mode update and the drive choice, and is the output register.
// Throughput: one transaction per cycle while m_axis_tready is high; the mode
// state loop closes in stage 2 so back-to-back ticks never wait on each other.
// Reset (arst_n low): mode idle, direction stopped, counters and angles zero,
// last homing end = max, registers at their defaults, both streams empty.
// Stall: when m_axis_tready is low the result holds; stage 1 still takes one
// more transaction, after which s_axis_tready drops until the result leaves.
module blind_motor_position_controller
	import bmpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] right_pressed, [1] left_pressed, [13:2] raw_angle, [15:14] zero
	input  logic [15:0] s_axis_tdata,
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] motor_drive, [10:2] target_angle, [12:11] control_mode,
	// [21:13] measured_angle, [23:22] zero
	output logic [23:0] m_axis_tdata
);

	`include "blind_motor_position_controller_defines.svh"

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic [ANGLE_W-1:0] slack_q, min_angle_q, max_angle_q;
	logic [LIMIT_W-1:0] hold_limit_q, home_limit_q;
	logic               cfg_wr;
	logic [IDX_W-1:0]   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q      <= SLACK_RST;
			min_angle_q  <= MIN_ANGLE_RST;
			max_angle_q  <= MAX_ANGLE_RST;
			hold_limit_q <= HOLD_LIMIT_RST;
			home_limit_q <= HOME_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SLACK:      slack_q      <= pwdata[ANGLE_W-1:0];
				REG_MIN_ANGLE:  min_angle_q  <= pwdata[ANGLE_W-1:0];
				REG_MAX_ANGLE:  max_angle_q  <= pwdata[ANGLE_W-1:0];
				REG_HOLD_LIMIT: hold_limit_q <= pwdata[LIMIT_W-1:0];
				REG_HOME_LIMIT: home_limit_q <= pwdata[LIMIT_W-1:0];
				default: ; // unmapped, ignored
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_SLACK:      prdata = 32'(slack_q);
			REG_MIN_ANGLE:  prdata = 32'(min_angle_q);
			REG_MAX_ANGLE:  prdata = 32'(max_angle_q);
			REG_HOLD_LIMIT: prdata = 32'(hold_limit_q);
			REG_HOME_LIMIT: prdata = 32'(home_limit_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control: stage 1 -> stage 2 (output register)
	// ------------------------------------------------------------------
	logic v_s1, v_s2;
	logic adv_s2;   // stage 1 item moves into the output register
	logic in_acc;

	assign adv_s2        = v_s1 & (~v_s2 | m_axis_tready);
	assign s_axis_tready = ~v_s1 | adv_s2;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_acc)
				v_s1 <= 1'b1;
			else if (adv_s2)
				v_s1 <= 1'b0;
			if (adv_s2)
				v_s2 <= 1'b1;
			else if (m_axis_tready)
				v_s2 <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture buttons, scale product raw*359
	// ------------------------------------------------------------------
	logic              right_s1, left_s1;
	logic [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			right_s1 <= s_axis_tdata[0];
			left_s1  <= s_axis_tdata[1];
			prod_s1  <= PROD_W'(s_axis_tdata[2 +: RAW_W]) * PROD_W'(SCALE_MUL);
		end
	end

	// ------------------------------------------------------------------
	// Controller state
	// ------------------------------------------------------------------
	logic [ANGLE_W-1:0] angle_now_q, angle_goal_q;
	drive_t             move_dir_q;
	mode_t              op_mode_q;
	logic               last_max_q;
	logic [LIMIT_W-1:0] right_hold_q, left_hold_q;
	logic [HOME_W-1:0]  home_hold_q;

	logic [ANGLE_W-1:0] angle_now_d, angle_goal_d, angle_gap;
	drive_t             move_dir_d, drive;
	mode_t              op_mode_d;
	logic               last_max_d;
	logic [LIMIT_W-1:0] right_hold_d, left_hold_d;
	logic [HOME_W-1:0]  home_hold_d;

	// button logic runs on the previous measured angle
	always_comb begin
		angle_goal_d = angle_goal_q;
		move_dir_d   = move_dir_q;
		op_mode_d    = op_mode_q;
		last_max_d   = last_max_q;
		right_hold_d = right_hold_q;
		left_hold_d  = left_hold_q;
		home_hold_d  = home_hold_q;

		priority if (right_s1 && left_s1) begin
			if (op_mode_q != MODE_HOMING &&
			    home_hold_q > HOME_W'(home_limit_q)) begin
				home_hold_d = '0;
				op_mode_d   = MODE_HOMING;
				last_max_d  = ~last_max_q;
				if (last_max_q) begin
					move_dir_d   = DRIVE_BACK;
					angle_goal_d = min_angle_q;
				end else begin
					move_dir_d   = DRIVE_FWD;
					angle_goal_d = max_angle_q;
				end
			end else if (home_hold_q != '1) begin
				home_hold_d = home_hold_q + HOME_W'(1);
			end
		end else if (right_s1) begin
			if (right_hold_q < hold_limit_q) begin
				right_hold_d = right_hold_q + LIMIT_W'(1);
			end else begin
				right_hold_d = '0;
				op_mode_d    = MODE_MANUAL;
				angle_goal_d = max_angle_q;
				move_dir_d   = DRIVE_FWD;
			end
		end else if (left_s1) begin
			if (left_hold_q < hold_limit_q) begin
				left_hold_d = left_hold_q + LIMIT_W'(1);
			end else begin
				left_hold_d  = '0;
				op_mode_d    = MODE_MANUAL;
				angle_goal_d = min_angle_q;
				move_dir_d   = DRIVE_BACK;
			end
		end else begin
			if (op_mode_q == MODE_MANUAL) begin
				// release during manual movement: stop where we are
				right_hold_d = '0;
				left_hold_d  = '0;
				op_mode_d    = MODE_IDLE;
				move_dir_d   = DRIVE_STOP;
				angle_goal_d = angle_now_q;
			end
		end
	end

	// new measured angle and drive choice
	always_comb begin
		angle_now_d = div4095(prod_s1);
		angle_gap = (angle_now_d >= angle_goal_d) ? angle_now_d - angle_goal_d
		                                          : angle_goal_d - angle_now_d;
		priority if (angle_gap <= slack_q)
			drive = DRIVE_STOP;
		else if (move_dir_d == DRIVE_FWD || angle_now_d < min_angle_q)
			drive = DRIVE_FWD;
		else if (move_dir_d == DRIVE_BACK || angle_now_d > max_angle_q)
			drive = DRIVE_BACK;
		else
			drive = DRIVE_STOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_now_q  <= '0;
			angle_goal_q <= '0;
			move_dir_q   <= DRIVE_STOP;
			op_mode_q    <= MODE_IDLE;
			last_max_q   <= 1'b1;
			right_hold_q <= '0;
			left_hold_q  <= '0;
			home_hold_q  <= '0;
		end else if (adv_s2) begin
			angle_now_q  <= angle_now_d;
			angle_goal_q <= angle_goal_d;
			move_dir_q   <= move_dir_d;
			op_mode_q    <= op_mode_d;
			last_max_q   <= last_max_d;
			right_hold_q <= right_hold_d;
			left_hold_q  <= left_hold_d;
			home_hold_q  <= home_hold_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: result register
	// ------------------------------------------------------------------
	drive_t             drive_s2;
	logic [ANGLE_W-1:0] target_s2, measured_s2;
	mode_t              mode_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			drive_s2    <= drive;
			target_s2   <= angle_goal_d;
			mode_s2     <= op_mode_d;
			measured_s2 <= angle_now_d;
		end
	end

	assign m_axis_tdata = {2'b00, measured_s2, mode_s2, target_s2, drive_s2};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// idle mode and stopped direction always change together
	`BMPC_ASSERT_NOW(a_idle_dir, 1'b1, (op_mode_q == MODE_IDLE) == (move_dir_q == DRIVE_STOP), "mode/direction mismatch")
	// divide by 4095 never exceeds full scale
	`BMPC_ASSERT_NOW(a_meas_range, v_s2, measured_s2 <= ANGLE_MAX_DEG, "measured angle out of range")
	// controller state only moves when a transaction leaves stage 1
	`BMPC_ASSERT_NEXT(a_state_hold, !adv_s2, $stable(op_mode_q) && $stable(home_hold_q), "state changed without transaction")

endmodule
